[design/fmp_pkg.sv]
package fmp_pkg;

  localparam int unsigned IndexBitsDefault = 63;
  localparam int unsigned IndexWidth       = 63;
  localparam int unsigned ResWidth         = 30;

  localparam logic [31:0] FibPrime   = 32'd1000000007;
  localparam logic [31:0] FibPrime2  = 32'd2000000014;
  // floor(2^60 / prime), Barrett reciprocal
  localparam logic [30:0] BarrettM   = 31'd1152921496;

  typedef struct packed {
    logic [ResWidth-1:0] lo;  // Fib(k)
    logic [ResWidth-1:0] hi;  // Fib(k+1)
  } fib_pair_t;

  // Reduce a value below three times the prime.
  function automatic logic [ResWidth-1:0] reduce3(input logic [31:0] s);
    logic [31:0] r;
    if (s >= FibPrime2) begin
      r = s - FibPrime2;
    end else if (s >= FibPrime) begin
      r = s - FibPrime;
    end else begin
      r = s;
    end
    return r[ResWidth-1:0];
  endfunction

  function automatic logic [ResWidth-1:0] mod_add(input logic [ResWidth-1:0] a,
                                                 input logic [ResWidth-1:0] b);
    return reduce3({2'b00, a} + {2'b00, b});
  endfunction

endpackage

[design/fmp_step.sv]
module fmp_step #(
  parameter int unsigned INDEX_BITS = fmp_pkg::IndexBitsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  fmp_pkg::fib_pair_t     pair_i,
  input  logic [INDEX_BITS-1:0]  idx_i,
  output logic                   valid_o,
  output fmp_pkg::fib_pair_t     pair_o,
  output logic [INDEX_BITS-1:0]  idx_o
);

  localparam int unsigned RW = fmp_pkg::ResWidth;

  logic [5:0] v_q;

  // stage 1: 2*Fib(k+1) - Fib(k)
  fmp_pkg::fib_pair_t    p1_q;
  logic [RW-1:0]         t1_q;
  logic [INDEX_BITS-1:0] idx1_q;
  // stage 2: raw products
  logic [59:0]           xe2_q, xa2_q, xb2_q;
  logic [INDEX_BITS-1:0] idx2_q;
  // stage 3: Barrett quotients
  logic [59:0]           xe3_q, xa3_q, xb3_q;
  logic [30:0]           qe3_q, qa3_q, qb3_q;
  logic [INDEX_BITS-1:0] idx3_q;
  // stage 4: quotient times prime, low words only
  logic [31:0]           xe4_q, xa4_q, xb4_q;
  logic [31:0]           me4_q, ma4_q, mb4_q;
  logic [INDEX_BITS-1:0] idx4_q;
  // stage 5: residues
  logic [RW-1:0]         re5_q, ra5_q, rb5_q;
  logic [INDEX_BITS-1:0] idx5_q;
  // stage 6: new pair
  fmp_pkg::fib_pair_t    p6_q;
  logic [INDEX_BITS-1:0] idx6_q;

  logic [31:0]   twice_d;
  logic [61:0]   pe3_d, pa3_d, pb3_d;
  logic [60:0]   me4_d, ma4_d, mb4_d;
  logic [RW-1:0] odd_d, sum_d;

  assign twice_d = {1'b0, pair_i.hi, 1'b0} + fmp_pkg::FibPrime - {2'b00, pair_i.lo};

  assign pe3_d = xe2_q[59:29] * fmp_pkg::BarrettM;
  assign pa3_d = xa2_q[59:29] * fmp_pkg::BarrettM;
  assign pb3_d = xb2_q[59:29] * fmp_pkg::BarrettM;

  assign me4_d = qe3_q * fmp_pkg::FibPrime[RW-1:0];
  assign ma4_d = qa3_q * fmp_pkg::FibPrime[RW-1:0];
  assign mb4_d = qb3_q * fmp_pkg::FibPrime[RW-1:0];

  assign odd_d = fmp_pkg::mod_add(ra5_q, rb5_q);
  assign sum_d = fmp_pkg::mod_add(re5_q, odd_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q   <= pair_i;
      t1_q   <= fmp_pkg::reduce3(twice_d);
      idx1_q <= idx_i;

      xe2_q  <= p1_q.lo * t1_q;
      xa2_q  <= p1_q.lo * p1_q.lo;
      xb2_q  <= p1_q.hi * p1_q.hi;
      idx2_q <= idx1_q;

      xe3_q  <= xe2_q;
      xa3_q  <= xa2_q;
      xb3_q  <= xb2_q;
      qe3_q  <= pe3_d[61:31];
      qa3_q  <= pa3_d[61:31];
      qb3_q  <= pb3_d[61:31];
      idx3_q <= idx2_q;

      xe4_q  <= xe3_q[31:0];
      xa4_q  <= xa3_q[31:0];
      xb4_q  <= xb3_q[31:0];
      me4_q  <= me4_d[31:0];
      ma4_q  <= ma4_d[31:0];
      mb4_q  <= mb4_d[31:0];
      idx4_q <= idx3_q;

      // remainder stays below three primes, so the low word suffices
      re5_q  <= fmp_pkg::reduce3(xe4_q - me4_q);
      ra5_q  <= fmp_pkg::reduce3(xa4_q - ma4_q);
      rb5_q  <= fmp_pkg::reduce3(xb4_q - mb4_q);
      idx5_q <= idx4_q;

      // a set bit advances the pair by one
      if (idx5_q[INDEX_BITS-1]) begin
        p6_q.lo <= odd_d;
        p6_q.hi <= sum_d;
      end else begin
        p6_q.lo <= re5_q;
        p6_q.hi <= odd_d;
      end
      idx6_q <= {idx5_q[INDEX_BITS-2:0], 1'b0};
    end
  end

  assign valid_o = v_q[5];
  assign pair_o  = p6_q;
  assign idx_o   = idx6_q;

endmodule

[design/fibonacci_mod_prime.sv]
// Fibonacci residue modulo 1000000007 by fast doubling. One index is taken
// every cycle while the output is not stalled. Each index bit has its own
// six-stage doubling step (modular difference, three products, Barrett
// quotient, quotient times prime, correction, pair update). Only the low
// INDEX_BITS bits of the index are walked. A stall on the output freezes
// the whole pipeline, so input ready follows output ready whenever a
// result is waiting.
module fibonacci_mod_prime #(
  parameter int unsigned INDEX_BITS = fmp_pkg::IndexBitsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [fmp_pkg::IndexWidth-1:0] fib_index_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [fmp_pkg::ResWidth-1:0]   fib_residue_o
);

  logic                  en;
  logic [63:0]           idx_wide;
  logic                  valid [INDEX_BITS+1];
  fmp_pkg::fib_pair_t    pair  [INDEX_BITS+1];
  logic [INDEX_BITS-1:0] idx   [INDEX_BITS+1];

  // advance whenever the final stage is empty or its transaction leaves
  assign en = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  assign idx_wide   = {1'b0, fib_index_i};
  assign valid[0]   = in_valid_i;
  assign pair[0].lo = '0;
  assign pair[0].hi = fmp_pkg::ResWidth'(1);
  assign idx[0]     = idx_wide[INDEX_BITS-1:0];

  for (genvar g = 0; g < INDEX_BITS; g++) begin : g_step
    fmp_step #(
      .INDEX_BITS(INDEX_BITS)
    ) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(valid[g]),
      .pair_i (pair[g]),
      .idx_i  (idx[g]),
      .valid_o(valid[g+1]),
      .pair_o (pair[g+1]),
      .idx_o  (idx[g+1])
    );
  end

  assign out_valid_o   = valid[INDEX_BITS];
  assign fib_residue_o = pair[INDEX_BITS].lo;

endmodule

[test/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdxW = fmp_pkg::IndexWidth;
  localparam int unsigned ResW = fmp_pkg::ResWidth;
  localparam int unsigned WalkBits = fmp_pkg::IndexBitsDefault;
  localparam longint unsigned Prime = 64'd1000000007;
  localparam int unsigned Latency = 6 * WalkBits;
  localparam int unsigned StallLimit = 20000;

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_ready_o;
  logic [IdxW-1:0] fib_index_i;
  logic            out_valid_o;
  logic            out_ready_i;
  logic [ResW-1:0] fib_residue_o;

  fibonacci_mod_prime dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .fib_index_i(fib_index_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .fib_residue_o(fib_residue_o)
  );

  logic [IdxW-1:0] pending_idx_q[$];
  logic [ResW-1:0] expected_res_q[$];
  int unsigned mismatches;
  int unsigned quiet_cycles;
  bit          calm_phase;
  bit          drain_req;
  int unsigned hold_off;
  bit          stim_done;
  // Handshake as seen at the last rising edge, to tell whether the item went.
  logic        in_ready_q;

  // Fast doubling over the walked index bits, most significant first.
  function automatic logic [ResW-1:0] fib_mod_prime(input logic [IdxW-1:0] idx);
    longint unsigned lo, hi, dbl, even, odd;
    lo = 0;
    hi = 1;
    for (int b = WalkBits - 1; b >= 0; b--) begin
      dbl  = (2 * hi + Prime - lo) % Prime;
      even = (lo * dbl) % Prime;
      odd  = ((lo * lo) % Prime + (hi * hi) % Prime) % Prime;
      if (idx[b]) begin
        lo = odd;
        hi = (even + odd) % Prime;
      end else begin
        lo = even;
        hi = odd;
      end
    end
    return lo[ResW-1:0];
  endfunction

  function automatic logic [IdxW-1:0] rand_index();
    logic [IdxW-1:0] v;
    v = IdxW'({$urandom, $urandom});
    case ($urandom_range(0, 4))
      0: v = v & IdxW'($urandom_range(0, 255));
      1: v = v >> $urandom_range(0, IdxW - 1);
      2: v = ~(v >> $urandom_range(0, IdxW - 1));
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Driver: offer queued transactions at the falling edge.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      fib_index_i <= '0;
    end else if (in_valid_i && !in_ready_q) begin
      // hold until accepted
    end else if (pending_idx_q.size() > 0 && !drain_req &&
                 (calm_phase || $urandom_range(0, 99) >= 26)) begin
      in_valid_i  <= 1'b1;
      fib_index_i <= pending_idx_q.pop_front();
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  always @(posedge clk_i) in_ready_q <= in_valid_i && in_ready_o;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_off > 0) begin
      out_ready_i <= 1'b0;
      hold_off    <= hold_off - 1;
    end else begin
      out_ready_i <= calm_phase || ($urandom_range(0, 99) >= 26);
    end
  end

  // Monitor: predict on input acceptance, check on output acceptance.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) expected_res_q.push_back(fib_mod_prime(fib_index_i));
      if (out_valid_o && out_ready_i) begin
        if (expected_res_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %0d", fib_residue_o);
        end else begin
          logic [ResW-1:0] want;
          want = expected_res_q.pop_front();
          if (fib_residue_o !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("fib_residue expected %0d actual %0d", want, fib_residue_o);
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("fibonacci_mod_prime: mismatch");
        $finish;
      end
    end
  end

  task automatic wait_taken();
    while (pending_idx_q.size() > 0 || in_valid_i) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    wait_taken();
    while (expected_res_q.size() > 0) @(posedge clk_i);
  endtask

  initial begin
    mismatches = 0;
    quiet_cycles = 0;
    calm_phase = 1'b0;
    drain_req = 1'b0;
    hold_off = 0;
    in_valid_i = 1'b0;
    fib_index_i = '0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    // Directed: zero, small indices, single bits, all ones, alternating patterns, values near the prime.
    for (int i = 0; i < 8; i++) pending_idx_q.push_back(IdxW'(i));
    pending_idx_q.push_back({IdxW{1'b1}});
    pending_idx_q.push_back({1'b1, {(IdxW-1){1'b0}}});
    pending_idx_q.push_back({1'b0, {(IdxW-1){1'b1}}});
    pending_idx_q.push_back(IdxW'(64'h5555_5555_5555_5555));
    pending_idx_q.push_back(IdxW'(64'h2AAA_AAAA_AAAA_AAAA));
    pending_idx_q.push_back(IdxW'(1000000007));
    pending_idx_q.push_back(IdxW'(2000000016));
    wait_taken();
    // Random with idling.
    for (int i = 0; i < 400; i++) pending_idx_q.push_back(rand_index());
    wait_taken();
    // Sender pauses until everything is back.
    drain_req = 1'b1;
    wait_drained();
    drain_req = 1'b0;
    // Long receiver hold-off while the sender keeps offering.
    hold_off = Latency + 200;
    calm_phase = 1'b1;
    for (int i = 0; i < 500; i++) pending_idx_q.push_back(rand_index());
    wait_taken();
    calm_phase = 1'b0;
    for (int i = 0; i < 435; i++) pending_idx_q.push_back(rand_index());
    wait_drained();
    repeat (Latency + 20) @(posedge clk_i);
    if (mismatches == 0 && expected_res_q.size() == 0) begin
      $display("fibonacci_mod_prime: match");
    end else begin
      $display("fibonacci_mod_prime: mismatch");
    end
    $finish;
  end

endmodule

[files.f]
design/fmp_pkg.sv
design/fmp_step.sv
design/fibonacci_mod_prime.sv
test/tb_top.sv
